[hdl/pmte_pkg.sv]
// pmte_pkg: types and fixed constants for the page table map engine.
// No dependencies; used by pmte_walker, page_table_map_engine and the testbench.
`default_nettype none
package pmte_pkg;

    localparam logic [1:0] MODE_MAP_4K = 2'd0;
    localparam logic [1:0] MODE_MAP_2M = 2'd1;
    localparam logic [1:0] MODE_MMIO   = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_OUTSIDE = 2'd2
    } pmte_status_t;

    // entry attribute bits
    localparam logic [11:0] E_PRESENT = 12'h001;
    localparam logic [11:0] E_WRITE   = 12'h002;
    localparam logic [11:0] E_PWT     = 12'h008;
    localparam logic [11:0] E_PCD     = 12'h010;
    localparam logic [11:0] E_HUGE    = 12'h080;
    localparam logic [11:0] MMIO_FLAGS = E_PRESENT | E_WRITE | E_PWT | E_PCD;

    localparam logic [51:0] POOL_BASE_RESET = 52'h0000000100000;

    localparam int unsigned AW = 54;  // MMIO walk address width
    localparam logic [AW-1:0] SMALL_SZ = AW'(64'h1000);
    localparam logic [AW-1:0] HUGE_SZ  = AW'(64'h200000);
    localparam logic [AW-1:0] LOW12    = AW'(64'hFFF);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_STEP,
        S_LOOKUP,
        S_CHECK,
        S_READ,
        S_DONE
    } pmte_state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] virt_addr;
        logic [51:0] phys_addr;
        logic [11:0] flags;
        logic [40:0] range_size;
        logic [5:0]  table_index;
        logic [8:0]  entry_index;
    } pmte_in_t;

    typedef struct packed {
        pmte_status_t status;
        logic [63:0]  read_data;
        logic [28:0]  pages_small;
        logic [19:0]  pages_huge;
        logic [6:0]   tables_used;
        logic [47:0]  invalidate_addr;
    } pmte_out_t;

endpackage
`default_nettype wire

[hdl/pmte_table_ram.sv]
// pmte_table_ram: table pool storage, one write and one registered read port.
// Depends on nothing.
`default_nettype none
module pmte_table_ram #(
    parameter int unsigned ADDR_W = 15
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [63:0]       wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [63:0]       rdata
);
    logic [63:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[hdl/pmte_walker.sv]
// pmte_walker: request sequencer, table walk, allocation and table clearing.
// Depends on pmte_pkg and pmte_table_ram.
`default_nettype none
module pmte_walker #(
    parameter int unsigned POOL_TABLES = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [51:0]         pool_base,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire pmte_pkg::pmte_in_t  req,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output pmte_pkg::pmte_out_t      res
);
    localparam int unsigned TW = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int unsigned NW = $clog2(POOL_TABLES + 1);
    localparam int unsigned MW = TW + 9;
    localparam int unsigned AW = pmte_pkg::AW;

    pmte_pkg::pmte_state_t  state_reg, state_next;
    pmte_pkg::pmte_status_t status_reg, status_next;
    logic [NW-1:0] next_table_reg, next_table_next;
    logic [TW-1:0] cur_tbl_reg, cur_tbl_next;
    logic [TW-1:0] clr_tbl_reg, clr_tbl_next;
    logic [8:0]    clr_cnt_reg, clr_cnt_next;
    logic          ret_idle_reg, ret_idle_next;
    logic [1:0]    level_reg, level_next;
    logic [1:0]    mode_reg, mode_next;
    logic          huge_reg, huge_next;
    logic [47:0]   va_reg, va_next;
    logic [AW-1:0] pa_reg, pa_next;
    logic [11:0]   fl_reg, fl_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] end_reg, end_next;
    logic [5:0]    ti_reg, ti_next;
    logic [63:0]   rd_reg, rd_next;
    logic [28:0]   small_reg, small_next;
    logic [19:0]   hcnt_reg, hcnt_next;
    logic [47:0]   inval_reg, inval_next;

    logic          ram_we, ram_re;
    logic [MW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;

    pmte_table_ram #(.ADDR_W(MW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared decode
    logic          accept;
    logic [8:0]    vidx;
    logic          at_leaf;
    logic [63:0]   ent_a, base_a, diff_a, new_tbl_addr;
    logic          in_pool, pool_full, read_oob, range_left, use_huge;
    logic [AW-1:0] range_rem, pa_small, pa_huge;

    assign accept = req_valid && req_ready;
    assign at_leaf = huge_reg ? (level_reg == 2'd2) : (level_reg == 2'd3);

    always_comb
    begin
        unique case (level_reg)
            2'd0: vidx = va_reg[47:39];
            2'd1: vidx = va_reg[38:30];
            2'd2: vidx = va_reg[29:21];
            default: vidx = va_reg[20:12];
        endcase
    end

    assign ent_a  = {ram_rdata[63:12], 12'h000};
    assign base_a = {12'h000, pool_base[51:12], 12'h000};
    assign diff_a = ent_a - base_a;
    assign in_pool = (ent_a >= base_a) &&
                     (diff_a[63:12] < 52'(next_table_reg));
    assign pool_full = (next_table_reg == NW'(POOL_TABLES));
    assign new_tbl_addr = base_a + {(52 - NW)'(0), next_table_reg, 12'h000};
    assign read_oob = (32'(req.table_index) >= 32'(POOL_TABLES));

    assign range_left = (addr_reg < end_reg);
    assign range_rem  = end_reg - addr_reg;
    assign use_huge   = (addr_reg[20:0] == 21'd0) && (range_rem >= pmte_pkg::HUGE_SZ);
    assign pa_small   = pa_reg & ~pmte_pkg::LOW12;
    assign pa_huge    = {pa_reg[AW-1:21], 21'd0};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pmte_pkg::S_CLEAR:
                if (clr_cnt_reg == 9'h1FF)
                    state_next = ret_idle_reg ? pmte_pkg::S_IDLE : pmte_pkg::S_LOOKUP;
            pmte_pkg::S_IDLE:
                if (accept)
                begin
                    unique case (req.mode)
                        pmte_pkg::MODE_MMIO: state_next = pmte_pkg::S_STEP;
                        pmte_pkg::MODE_READ:
                            state_next = read_oob ? pmte_pkg::S_DONE : pmte_pkg::S_READ;
                        default: state_next = pmte_pkg::S_LOOKUP;
                    endcase
                end
            pmte_pkg::S_STEP:
                state_next = range_left ? pmte_pkg::S_LOOKUP : pmte_pkg::S_DONE;
            pmte_pkg::S_LOOKUP:
                if (at_leaf)
                    state_next = (mode_reg == pmte_pkg::MODE_MMIO) ?
                                 pmte_pkg::S_STEP : pmte_pkg::S_DONE;
                else
                    state_next = pmte_pkg::S_CHECK;
            pmte_pkg::S_CHECK:
                if (!ram_rdata[0])
                    state_next = pool_full ? pmte_pkg::S_DONE : pmte_pkg::S_CLEAR;
                else
                    state_next = in_pool ? pmte_pkg::S_LOOKUP : pmte_pkg::S_DONE;
            pmte_pkg::S_READ:
                state_next = pmte_pkg::S_DONE;
            pmte_pkg::S_DONE:
                if (res_ready)
                    state_next = pmte_pkg::S_IDLE;
            default:
                state_next = pmte_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        status_next     = status_reg;
        next_table_next = next_table_reg;
        cur_tbl_next    = cur_tbl_reg;
        clr_tbl_next    = clr_tbl_reg;
        clr_cnt_next    = clr_cnt_reg;
        ret_idle_next   = ret_idle_reg;
        level_next      = level_reg;
        mode_next       = mode_reg;
        huge_next       = huge_reg;
        va_next         = va_reg;
        pa_next         = pa_reg;
        fl_next         = fl_reg;
        addr_next       = addr_reg;
        end_next        = end_reg;
        ti_next         = ti_reg;
        rd_next         = rd_reg;
        small_next      = small_reg;
        hcnt_next       = hcnt_reg;
        inval_next      = inval_reg;
        ram_we    = 1'b0;
        ram_waddr = {cur_tbl_reg, vidx};
        ram_wdata = 64'd0;
        ram_re    = 1'b0;
        ram_raddr = {cur_tbl_reg, vidx};

        unique case (state_reg)
            pmte_pkg::S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = {clr_tbl_reg, clr_cnt_reg};
                clr_cnt_next = clr_cnt_reg + 9'd1;
            end
            pmte_pkg::S_IDLE:
                if (accept)
                begin
                    mode_next    = req.mode;
                    status_next  = pmte_pkg::ST_OK;
                    rd_next      = 64'd0;
                    small_next   = 29'd0;
                    hcnt_next    = 20'd0;
                    inval_next   = 48'd0;
                    level_next   = 2'd0;
                    cur_tbl_next = TW'(0);
                    va_next      = req.virt_addr;
                    pa_next      = AW'(req.phys_addr);
                    fl_next      = req.flags;
                    huge_next    = (req.mode == pmte_pkg::MODE_MAP_2M);
                    ti_next      = req.table_index;
                    addr_next    = AW'(req.phys_addr) & ~pmte_pkg::LOW12;
                    end_next     = (AW'(req.phys_addr) + AW'(req.range_size) +
                                    pmte_pkg::LOW12) & ~pmte_pkg::LOW12;
                    if (req.mode == pmte_pkg::MODE_READ)
                    begin
                        if (read_oob)
                            status_next = pmte_pkg::ST_OUTSIDE;
                        else
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = {TW'(req.table_index), req.entry_index};
                        end
                    end
                end
            pmte_pkg::S_STEP:
            begin
                huge_next    = use_huge;
                va_next      = addr_reg[47:0];
                pa_next      = addr_reg;
                fl_next      = pmte_pkg::MMIO_FLAGS;
                level_next   = 2'd0;
                cur_tbl_next = TW'(0);
            end
            pmte_pkg::S_LOOKUP:
                if (at_leaf)
                begin
                    ram_we = 1'b1;
                    if (huge_reg)
                    begin
                        ram_wdata  = 64'(pa_huge) | 64'(fl_reg) | 64'(pmte_pkg::E_HUGE);
                        hcnt_next  = hcnt_reg + 20'd1;
                        inval_next = {va_reg[47:21], 21'd0};
                        addr_next  = addr_reg + pmte_pkg::HUGE_SZ;
                    end
                    else
                    begin
                        ram_wdata  = 64'(pa_small) | 64'(fl_reg);
                        small_next = small_reg + 29'd1;
                        inval_next = {va_reg[47:12], 12'd0};
                        addr_next  = addr_reg + pmte_pkg::SMALL_SZ;
                    end
                end
                else
                    ram_re = 1'b1;
            pmte_pkg::S_CHECK:
                if (!ram_rdata[0])
                begin
                    if (pool_full)
                        status_next = pmte_pkg::ST_FULL;
                    else
                    begin
                        // link a fresh table, then sweep it to zero
                        ram_we          = 1'b1;
                        ram_wdata       = new_tbl_addr |
                                          64'(pmte_pkg::E_PRESENT | pmte_pkg::E_WRITE);
                        cur_tbl_next    = next_table_reg[TW-1:0];
                        clr_tbl_next    = next_table_reg[TW-1:0];
                        clr_cnt_next    = 9'd0;
                        ret_idle_next   = 1'b0;
                        next_table_next = next_table_reg + NW'(1);
                        level_next      = level_reg + 2'd1;
                    end
                end
                else if (in_pool)
                begin
                    cur_tbl_next = diff_a[12 +: TW];
                    level_next   = level_reg + 2'd1;
                end
                else
                    status_next = pmte_pkg::ST_OUTSIDE;
            pmte_pkg::S_READ:
                rd_next = (32'(ti_reg) < 32'(next_table_reg)) ? ram_rdata : 64'd0;
            pmte_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pmte_pkg::S_CLEAR;
            next_table_reg <= NW'(1);
            clr_tbl_reg    <= TW'(0);
            clr_cnt_reg    <= 9'd0;
            ret_idle_reg   <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            next_table_reg <= next_table_next;
            clr_tbl_reg    <= clr_tbl_next;
            clr_cnt_reg    <= clr_cnt_next;
            ret_idle_reg   <= ret_idle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        cur_tbl_reg <= cur_tbl_next;
        level_reg   <= level_next;
        mode_reg    <= mode_next;
        huge_reg    <= huge_next;
        va_reg      <= va_next;
        pa_reg      <= pa_next;
        fl_reg      <= fl_next;
        addr_reg    <= addr_next;
        end_reg     <= end_next;
        ti_reg      <= ti_next;
        rd_reg      <= rd_next;
        small_reg   <= small_next;
        hcnt_reg    <= hcnt_next;
        inval_reg   <= inval_next;
    end

    assign req_ready = (state_reg == pmte_pkg::S_IDLE);
    assign res_valid = (state_reg == pmte_pkg::S_DONE);

    always_comb
    begin
        res.status          = status_reg;
        res.read_data       = rd_reg;
        res.pages_small     = small_reg;
        res.pages_huge      = hcnt_reg;
        res.tables_used     = 7'(next_table_reg);
        res.invalidate_addr = inval_reg;
    end
endmodule
`default_nettype wire

[hdl/page_table_map_engine.sv]
// page_table_map_engine: top level; pool base register and result register.
// Depends on pmte_pkg and pmte_walker (which holds pmte_table_ram).
//
//  channel | direction | beat                 | handshake
//  --------+-----------+----------------------+---------------------
//  in      | input     | pmte_in_t request    | in_valid / in_ready
//  out     | output    | pmte_out_t result    | out_valid / out_ready
//  cfg     | input     | 52-bit pool_base     | cfg_valid / cfg_ready
//
// After reset the root table is swept to zero; in_ready stays low meanwhile.
// Each level walked takes a lookup state (RAM read) and a check state, the leaf a lookup
// state with the entry write, and each new table is swept to zero before the walk goes on.
// A read takes a read state; MMIO runs a step state at the start and one after each page.
// The walk is paced by the table RAM. A finished result waits in the output register
// while the next request runs; the engine holds its following result until that drains.
`default_nettype none
module page_table_map_engine #(
    parameter int unsigned POOL_TABLES = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire pmte_pkg::pmte_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output pmte_pkg::pmte_out_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [51:0]         cfg_data
);
    logic [51:0]         pool_base_reg;
    logic                out_valid_reg;
    pmte_pkg::pmte_out_t out_data_reg;
    logic                res_valid, res_ready;
    pmte_pkg::pmte_out_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pool_base_reg <= pmte_pkg::POOL_BASE_RESET;
        else if (cfg_valid && cfg_ready)
            pool_base_reg <= cfg_data;
    end

    pmte_walker #(.POOL_TABLES(POOL_TABLES)) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .pool_base (pool_base_reg),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req       (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // result register frees the walker from the consumer
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
endmodule
`default_nettype wire

[bench/testbench.sv]
// testbench: self-checking bench for page_table_map_engine, with a directed table and
// random requests checked beat by beat against a local page table predictor.
// Depends on pmte_pkg and the page_table_map_engine RTL.
`default_nettype none
module testbench;

    localparam int POOL = 64;
    localparam logic [63:0] VA_MASK = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] PG_4K = 64'h1000;
    localparam logic [63:0] PG_2M = 64'h20_0000;
    localparam logic [63:0] OFF_4K = 64'hFFF;
    localparam logic [63:0] OFF_2M = 64'h1F_FFFF;
    localparam logic [51:0] PA_TOP = 52'hF_FFFF_FFFF_FFFF;
    localparam logic [51:0] BASE_TOP = 52'hF_FFFF_FFFF_F000;
    localparam int HOLD_AT_BEAT = 40;    // result beat count that starts the long hold-off
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 600;
    localparam int IN_W = $bits(pmte_pkg::pmte_in_t);

    typedef struct {
        pmte_pkg::pmte_in_t  req;
        bit                  typed;   // want holds a hand-written result
        pmte_pkg::pmte_out_t want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    pmte_pkg::pmte_in_t  in_data;
    logic                out_valid;
    logic                out_ready;
    pmte_pkg::pmte_out_t out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [51:0]         cfg_data;

    page_table_map_engine #(.POOL_TABLES(POOL)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the table pool and the base reg
    // ------------------------------------------------------------------
    logic [63:0] page_mem [POOL*512];
    int          next_free;
    logic [51:0] base_reg;
    logic [63:0] n_small;
    logic [63:0] n_huge;
    logic [63:0] flush_va;

    stim_row_t           pending_q[$];   // rows driven, awaiting their accept beat
    pmte_pkg::pmte_out_t result_q[$];    // expected results, oldest first
    int          errors;
    int          rx_beats;
    logic [63:0] regions [4];    // clustered VA windows so walks reuse tables

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] tbl_phys(int t);
        return ({12'b0, base_reg} & ~OFF_4K) + 64'(t) * PG_4K;
    endfunction

    function automatic logic [8:0] va_slot(logic [63:0] va, int sh);
        return 9'((va >> sh) & 64'h1FF);
    endfunction

    // Follow the entry, or allocate and clear a fresh table behind it.
    // A present entry must point at an allocated pool table, huge or not.
    function automatic pmte_pkg::pmte_status_t descend(int tbl, logic [8:0] idx,
                                                       output int child);
        logic [63:0] e;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] off;
        int slot;
        slot = tbl * 512 + int'(idx);
        e = page_mem[slot];
        child = 0;
        if (!e[0])
        begin
            if (next_free >= POOL)
                return pmte_pkg::ST_FULL;
            child = next_free;
            next_free++;
            for (int i = 0; i < 512; i++)
                page_mem[child*512 + i] = '0;
            page_mem[slot] = tbl_phys(child) | 64'(pmte_pkg::E_PRESENT | pmte_pkg::E_WRITE);
            return pmte_pkg::ST_OK;
        end
        a = e & ~OFF_4K;
        b = {12'b0, base_reg} & ~OFF_4K;
        if (a < b)
            return pmte_pkg::ST_OUTSIDE;
        off = (a - b) >> 12;
        if (off >= 64'(next_free))
            return pmte_pkg::ST_OUTSIDE;
        child = int'(off);
        return pmte_pkg::ST_OK;
    endfunction

    function automatic pmte_pkg::pmte_status_t to_pd(logic [63:0] va, output int pd);
        int pdpt;
        pmte_pkg::pmte_status_t s;
        pd = 0;
        s = descend(0, va_slot(va, 39), pdpt);
        if (s != pmte_pkg::ST_OK)
            return s;
        return descend(pdpt, va_slot(va, 30), pd);
    endfunction

    function automatic pmte_pkg::pmte_status_t put_small(logic [63:0] va, logic [63:0] pa,
                                                         logic [63:0] fl);
        int pd;
        int pt;
        pmte_pkg::pmte_status_t s;
        s = to_pd(va, pd);
        if (s != pmte_pkg::ST_OK)
            return s;
        s = descend(pd, va_slot(va, 21), pt);
        if (s != pmte_pkg::ST_OK)
            return s;
        page_mem[pt*512 + int'(va_slot(va, 12))] = (pa & ~OFF_4K) | fl;
        n_small++;
        flush_va = va & ~OFF_4K & VA_MASK;
        return pmte_pkg::ST_OK;
    endfunction

    function automatic pmte_pkg::pmte_status_t put_huge(logic [63:0] va, logic [63:0] pa,
                                                        logic [63:0] fl);
        int pd;
        pmte_pkg::pmte_status_t s;
        s = to_pd(va, pd);
        if (s != pmte_pkg::ST_OK)
            return s;
        page_mem[pd*512 + int'(va_slot(va, 21))] =
            (pa & ~OFF_2M) | fl | 64'(pmte_pkg::E_HUGE);
        n_huge++;
        flush_va = va & ~OFF_2M & VA_MASK;
        return pmte_pkg::ST_OK;
    endfunction

    function automatic pmte_pkg::pmte_out_t predict_result(pmte_pkg::pmte_in_t r);
        pmte_pkg::pmte_out_t o;
        pmte_pkg::pmte_status_t s;
        logic [63:0] addr;
        logic [63:0] lim;
        logic [63:0] mf;
        s = pmte_pkg::ST_OK;
        o = '0;
        n_small = 0;
        n_huge = 0;
        flush_va = 0;
        mf = 64'(pmte_pkg::MMIO_FLAGS);
        if (r.mode == pmte_pkg::MODE_MAP_4K)
            s = put_small(64'(r.virt_addr), 64'(r.phys_addr), 64'(r.flags));
        else if (r.mode == pmte_pkg::MODE_MAP_2M)
            s = put_huge(64'(r.virt_addr), 64'(r.phys_addr), 64'(r.flags));
        else if (r.mode == pmte_pkg::MODE_MMIO)
        begin
            // identity map; 2 MB pages where aligned with 2 MB still to go
            addr = 64'(r.phys_addr) & ~OFF_4K;
            lim = (64'(r.phys_addr) + 64'(r.range_size) + OFF_4K) & ~OFF_4K;
            while (addr < lim)
            begin
                if ((addr & OFF_2M) == 0 && lim - addr >= PG_2M)
                begin
                    s = put_huge(addr, addr, mf);
                    addr += PG_2M;
                end
                else
                begin
                    s = put_small(addr, addr, mf);
                    addr += PG_4K;
                end
                if (s != pmte_pkg::ST_OK)
                    break;
            end
        end
        else
        begin
            if (int'(r.table_index) >= POOL)
                s = pmte_pkg::ST_OUTSIDE;
            else
                o.read_data = page_mem[int'(r.table_index)*512 + int'(r.entry_index)];
        end
        o.status = s;
        o.pages_small = 29'(n_small);
        o.pages_huge = 20'(n_huge);
        o.tables_used = 7'(next_free);
        o.invalidate_addr = 48'(flush_va);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Monitors: request beats feed the predictor, result beats are checked
    // ------------------------------------------------------------------
    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH beat %0d %s: got %h want %h", rx_beats, field, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin : req_monitor
        stim_row_t row;
        pmte_pkg::pmte_out_t p;
        if (rst_n && cfg_valid && cfg_ready)
            base_reg <= cfg_data;
        if (rst_n && in_valid && in_ready)
        begin
            row = pending_q.pop_front();
            p = predict_result(row.req);
            result_q.push_back(row.typed ? row.want : p);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        pmte_pkg::pmte_out_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (result_q.size() == 0)
                report_mismatch("unexpected result", 64'(out_data.status), '0);
            else
            begin
                w = result_q.pop_front();
                if (out_data.status !== w.status)
                    report_mismatch("status", 64'(out_data.status), 64'(w.status));
                if (out_data.read_data !== w.read_data)
                    report_mismatch("read_data", out_data.read_data, w.read_data);
                if (out_data.pages_small !== w.pages_small)
                    report_mismatch("pages_small", 64'(out_data.pages_small),
                                    64'(w.pages_small));
                if (out_data.pages_huge !== w.pages_huge)
                    report_mismatch("pages_huge", 64'(out_data.pages_huge),
                                    64'(w.pages_huge));
                if (out_data.tables_used !== w.tables_used)
                    report_mismatch("tables_used", 64'(out_data.tables_used),
                                    64'(w.tables_used));
                if (out_data.invalidate_addr !== w.invalidate_addr)
                    report_mismatch("invalidate_addr", 64'(out_data.invalidate_addr),
                                    64'(w.invalidate_addr));
            end
            rx_beats++;
        end
    end

    // Result side: a randomly drawn stall pattern; one long hold-off
    // lets the output register and the engine both fill, so in_ready drops.
    initial
    begin : result_sink
        int hold_left;
        int style;
        int tick;
        bit held;
        hold_left = 0;
        style = 0;
        tick = 0;
        held = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (tick % 128 == 0)
                style = $urandom_range(0, 3);
            tick++;
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!held && rx_beats >= HOLD_AT_BEAT)
            begin
                held = 1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                case (style)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 9) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int burst_left;

    task automatic drive_req(stim_row_t row);
        pending_q.push_back(row);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= row.req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic pause(int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Bursts of back-to-back beats, separated by random gaps
    task automatic send_paced(stim_row_t row);
        drive_req(row);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            pause($urandom_range(0, 8));
        end
    endtask

    task automatic wait_idle();
        pause(1);
        while (result_q.size() != 0 || pending_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_base(logic [51:0] v);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic pmte_pkg::pmte_in_t mk_req(logic [1:0] m, logic [47:0] va,
                                                  logic [51:0] pa, logic [11:0] fl,
                                                  logic [40:0] sz, logic [5:0] ti,
                                                  logic [8:0] ei);
        pmte_pkg::pmte_in_t r;
        r.mode = m;
        r.virt_addr = va;
        r.phys_addr = pa;
        r.flags = fl;
        r.range_size = sz;
        r.table_index = ti;
        r.entry_index = ei;
        return r;
    endfunction

    function automatic stim_row_t plain_row(pmte_pkg::pmte_in_t r);
        stim_row_t row;
        row.req = r;
        row.typed = 0;
        row.want = '0;
        return row;
    endfunction

    // Random request: every field random, then the fields the mode uses are
    // shaped so walks mostly land in a few windows and MMIO stays short.
    function automatic pmte_pkg::pmte_in_t rand_req();
        pmte_pkg::pmte_in_t r;
        logic [191:0] raw;
        int pick;
        logic [63:0] v;
        raw = {rnd64(), rnd64(), rnd64()};
        r = raw[IN_W-1:0];
        pick = $urandom_range(0, 99);
        v = regions[$urandom_range(0, 3)] + (rnd64() & 64'h3F_FFFF);
        if ($urandom_range(0, 9) != 0)
            r.virt_addr = v[47:0];
        if (pick < 35)
            r.mode = pmte_pkg::MODE_MAP_4K;
        else if (pick < 55)
            r.mode = pmte_pkg::MODE_MAP_2M;
        else if (pick < 75)
        begin
            r.mode = pmte_pkg::MODE_MMIO;
            if ($urandom_range(0, 4) != 0)
            begin
                r.phys_addr = v[51:0];
                r.range_size = 41'($urandom_range(0, 32'h4_0000));
            end
            else
            begin
                r.phys_addr = v[51:0] & ~52'h1F_FFFF;
                r.range_size = 41'($urandom_range(1, 8)) * 41'h20_0000
                               + 41'($urandom_range(0, 32'h3000));
            end
        end
        else
        begin
            r.mode = pmte_pkg::MODE_READ;
            if ($urandom_range(0, 2) != 0)
            begin
                r.table_index = 6'($urandom_range(0, 15));
                r.entry_index = va_slot(v, 12 + 9 * $urandom_range(0, 3));
            end
        end
        return r;
    endfunction

    function automatic pmte_pkg::pmte_out_t mk_out(pmte_pkg::pmte_status_t st,
                                                   logic [6:0] tu);
        pmte_pkg::pmte_out_t o;
        o = '0;
        o.status = st;
        o.tables_used = tu;
        return o;
    endfunction

    initial
    begin : main_flow
        stim_row_t dir_rows[$];
        stim_row_t row;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        rx_beats = 0;
        next_free = 1;
        base_reg = pmte_pkg::POOL_BASE_RESET;
        burst_left = 1;
        for (int i = 0; i < POOL*512; i++)
            page_mem[i] = '0;
        for (int k = 0; k < 4; k++)
            regions[k] = rnd64() & VA_MASK & ~64'h3F_FFFF;

        // Directed table. Typed results: read of the cleared root, empty range.
        row = plain_row(mk_req(pmte_pkg::MODE_READ, '0, '0, '0, '0, 6'd0, 9'd0));
        row.typed = 1;
        row.want = mk_out(pmte_pkg::ST_OK, 7'd1);
        dir_rows.push_back(row);
        row = plain_row(mk_req(pmte_pkg::MODE_MMIO, '1, 52'h5000, '0, '0, '1, '1));
        row.typed = 1;
        row.want = mk_out(pmte_pkg::ST_OK, 7'd1);
        dir_rows.push_back(row);
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_MAP_4K, '0, '0, '0, '0, '0, '0)));
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_MAP_4K, '1, PA_TOP, '1, '1,
                                            '0, '0)));
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_MAP_2M, 48'h4020_0000, PA_TOP,
                                            '1, '0, '0, '0)));
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_MAP_2M, '1, '0, 12'h000,
                                            '0, '0, '0)));
        // huge leaf over va 0, then a 4 KB walk through it points outside the pool
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_MAP_2M, '0, 52'h1234_5678,
                                            12'h003, '0, '0, '0)));
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_MAP_4K, 48'h1000, 52'h7000,
                                            12'h003, '0, '0, '0)));
        // MMIO: unaligned across a 2 MB line, aligned 2 MB pages, top of PA space
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_MMIO, '0, 52'h1F_F800, '0,
                                            41'h1000, '0, '0)));
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_MMIO, '0, 52'h4000_0000, '0,
                                            41'h40_0000, '0, '0)));
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_MMIO, '0, 52'hF_FFFF_FFFF_F000,
                                            '0, 41'h2000, '0, '0)));
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_MMIO, '0, 52'h60_0800, '0,
                                            41'h20_0000, '0, '0)));
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_READ, '0, '0, '0, '0,
                                            6'd1, 9'd0)));
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_READ, '0, '0, '0, '0,
                                            6'd3, 9'd0)));
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_READ, '0, '0, '0, '0,
                                            6'd3, 9'd511)));
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_READ, '1, '1, '1, '1,
                                            6'd63, 9'd511)));
        dir_rows.push_back(plain_row(mk_req(pmte_pkg::MODE_READ, '0, '0, '0, '0,
                                            6'd2, 9'd1)));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_paced(dir_rows[i]);

        // phase at the reset base
        for (int i = 0; i < 95; i++)
            send_paced(plain_row(rand_req()));

        // base at zero: old links now point elsewhere
        write_base('0);
        for (int i = 0; i < 55; i++)
            send_paced(plain_row(rand_req()));

        // base at the top of the range
        write_base(BASE_TOP);
        for (int i = 0; i < 55; i++)
            send_paced(plain_row(rand_req()));

        // back to the reset value
        write_base(pmte_pkg::POOL_BASE_RESET);
        for (int i = 0; i < 65; i++)
            send_paced(plain_row(rand_req()));

        // largest range last: runs until the pool is full or a link is foreign
        send_paced(plain_row(mk_req(pmte_pkg::MODE_MMIO, '0, '0, '0, 41'h100_0000_0000,
                                    '0, '0)));

        pause(1);
        while (result_q.size() != 0 || pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(8 * 4_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
